@@ hdl/bmprgb_pkg.sv @@
// bmprgb_pkg: types, codes and constants shared by the bmp to rgb565 decoder
// used by the front parser, the item queue, the back formatter and the top level
`default_nettype none

package bmprgb_pkg;

  localparam int unsigned MaxDim = 256;
  localparam int unsigned DimW   = $clog2(MaxDim + 1);

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0]  SigB        = 8'h42;
  localparam logic [7:0]  SigM        = 8'h4D;
  localparam logic [31:0] InfoMinSize = 32'd40;
  localparam logic [15:0] Bpp24       = 16'd24;
  localparam logic [15:0] Bpp32       = 16'd32;
  localparam logic [31:0] DataStart   = 32'd54;

  typedef enum logic [5:0] {
    ST_FHDR = 6'b000001,
    ST_INFO = 6'b000010,
    ST_SKIP = 6'b000100,
    ST_DATA = 6'b001000,
    ST_PAD  = 6'b010000,
    ST_IDLE = 6'b100000
  } front_state_e;

  typedef enum logic [1:0] {
    RES_PIXEL = 2'd0,
    RES_DONE  = 2'd1,
    RES_ERROR = 2'd2
  } res_kind_e;

  typedef enum logic [2:0] {
    ERR_SHORT_FHDR = 3'd0,
    ERR_SIGNATURE  = 3'd1,
    ERR_SHORT_INFO = 3'd2,
    ERR_INFO_SIZE  = 3'd3,
    ERR_BPP        = 3'd4,
    ERR_TOO_LARGE  = 3'd5,
    ERR_SEEK       = 3'd6,
    ERR_SHORT_DATA = 3'd7
  } err_e;

  typedef enum logic [1:0] {
    CMD_PIXEL      = 2'd0,
    CMD_DONE       = 2'd1,
    CMD_ERROR      = 2'd2,
    CMD_PIXEL_DONE = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  dest_row;
    logic [7:0]  dest_column;
    logic [23:0] bgr;
    logic        opaque;
    err_e        err;
    logic [8:0]  width;
    logic [8:0]  height;
    logic        has_mask;
  } q_entry_t;

endpackage

`default_nettype wire

@@ hdl/bmprgb_front.sv @@
// bmprgb_front: header parser and pixel byte collector, one byte per cycle while accept_i is high
// depends on bmprgb_pkg; pushes one queue entry per result-causing byte
`default_nettype none

module bmprgb_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire logic                  kind_i,
  input  wire logic [7:0]            data_byte_i,
  output logic                       push_o,
  output bmprgb_pkg::q_entry_t       entry_o
);

  localparam int unsigned DW = bmprgb_pkg::DimW;

  bmprgb_pkg::front_state_e state_q, state_d;
  logic [31:0]   pos_q, pos_d;
  logic [31:0]   hdr_q, hdr_d;
  logic [31:0]   width_q, width_d;
  logic [31:0]   height_q, height_d;
  logic [15:0]   bpp_q, bpp_d;
  logic [31:0]   offset_q, offset_d;
  logic [DW-1:0] row_q, row_d;
  logic [DW-1:0] col_q, col_d;
  logic [1:0]    idx_q, idx_d;
  logic [23:0]   pix_q, pix_d;
  logic [1:0]    pad_q, pad_d;
  logic          sig_q, sig_d;

  logic          go_data;
  logic          is32;
  logic [1:0]    last_idx;
  logic [31:0]   pos_inc;
  logic [DW-1:0] col_inc;
  logic [DW-1:0] row_inc;

  assign is32     = (bpp_q == bmprgb_pkg::Bpp32);
  assign last_idx = is32 ? 2'd3 : 2'd2;
  assign pos_inc  = pos_q + 32'd1;
  assign col_inc  = col_q + DW'(1);
  assign row_inc  = row_q + DW'(1);

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    hdr_d    = hdr_q;
    width_d  = width_q;
    height_d = height_q;
    bpp_d    = bpp_q;
    offset_d = offset_q;
    row_d    = row_q;
    col_d    = col_q;
    idx_d    = idx_q;
    pix_d    = pix_q;
    pad_d    = pad_q;
    sig_d    = sig_q;
    go_data  = 1'b0;
    push_o   = 1'b0;
    entry_o  = '0;

    if (accept_i) begin
      if (kind_i) begin
        // end of file: report by phase unless idle, then rearm
        push_o      = (state_q != bmprgb_pkg::ST_IDLE);
        entry_o.cmd = bmprgb_pkg::CMD_ERROR;
        unique case (state_q)
          bmprgb_pkg::ST_FHDR: entry_o.err = bmprgb_pkg::ERR_SHORT_FHDR;
          bmprgb_pkg::ST_INFO: entry_o.err = bmprgb_pkg::ERR_SHORT_INFO;
          bmprgb_pkg::ST_SKIP: entry_o.err = bmprgb_pkg::ERR_SEEK;
          default:             entry_o.err = bmprgb_pkg::ERR_SHORT_DATA;
        endcase
        state_d  = bmprgb_pkg::ST_FHDR;
        pos_d    = '0;
        hdr_d    = '0;
        width_d  = '0;
        height_d = '0;
        bpp_d    = '0;
        offset_d = '0;
        row_d    = '0;
        col_d    = '0;
        idx_d    = '0;
        pix_d    = '0;
        pad_d    = '0;
        sig_d    = 1'b0;
      end else begin
        unique case (state_q)
          bmprgb_pkg::ST_FHDR: begin
            pos_d = pos_inc;
            if (pos_q == 32'd0) begin
              sig_d = (data_byte_i == bmprgb_pkg::SigB);
            end else if (pos_q == 32'd1) begin
              sig_d = sig_q && (data_byte_i == bmprgb_pkg::SigM);
            end
            unique case (pos_q[3:0])
              4'd10:   offset_d[7:0]   = data_byte_i;
              4'd11:   offset_d[15:8]  = data_byte_i;
              4'd12:   offset_d[23:16] = data_byte_i;
              4'd13:   offset_d[31:24] = data_byte_i;
              default: offset_d        = offset_q;
            endcase
            if (pos_q == 32'd13) begin
              if (!sig_q) begin
                push_o      = 1'b1;
                entry_o.cmd = bmprgb_pkg::CMD_ERROR;
                entry_o.err = bmprgb_pkg::ERR_SIGNATURE;
                state_d     = bmprgb_pkg::ST_IDLE;
              end else begin
                state_d = bmprgb_pkg::ST_INFO;
              end
            end
          end
          bmprgb_pkg::ST_INFO: begin
            pos_d = pos_inc;
            unique case (pos_q[5:0])
              6'd14:   hdr_d[7:0]      = data_byte_i;
              6'd15:   hdr_d[15:8]     = data_byte_i;
              6'd16:   hdr_d[23:16]    = data_byte_i;
              6'd17:   hdr_d[31:24]    = data_byte_i;
              6'd18:   width_d[7:0]    = data_byte_i;
              6'd19:   width_d[15:8]   = data_byte_i;
              6'd20:   width_d[23:16]  = data_byte_i;
              6'd21:   width_d[31:24]  = data_byte_i;
              6'd22:   height_d[7:0]   = data_byte_i;
              6'd23:   height_d[15:8]  = data_byte_i;
              6'd24:   height_d[23:16] = data_byte_i;
              6'd25:   height_d[31:24] = data_byte_i;
              6'd28:   bpp_d[7:0]      = data_byte_i;
              6'd29:   bpp_d[15:8]     = data_byte_i;
              default: hdr_d           = hdr_q;
            endcase
            if (pos_q == 32'd53) begin
              entry_o.cmd = bmprgb_pkg::CMD_ERROR;
              priority if (hdr_q < bmprgb_pkg::InfoMinSize) begin
                push_o      = 1'b1;
                entry_o.err = bmprgb_pkg::ERR_INFO_SIZE;
                state_d     = bmprgb_pkg::ST_IDLE;
              end else if (bpp_q != bmprgb_pkg::Bpp24 && bpp_q != bmprgb_pkg::Bpp32) begin
                push_o      = 1'b1;
                entry_o.err = bmprgb_pkg::ERR_BPP;
                state_d     = bmprgb_pkg::ST_IDLE;
              end else if (width_q > 32'(bmprgb_pkg::MaxDim) ||
                           height_q > 32'(bmprgb_pkg::MaxDim)) begin
                push_o      = 1'b1;
                entry_o.err = bmprgb_pkg::ERR_TOO_LARGE;
                state_d     = bmprgb_pkg::ST_IDLE;
              end else if (offset_q < bmprgb_pkg::DataStart) begin
                push_o      = 1'b1;
                entry_o.err = bmprgb_pkg::ERR_SEEK;
                state_d     = bmprgb_pkg::ST_IDLE;
              end else if (offset_q == bmprgb_pkg::DataStart) begin
                go_data = 1'b1;
              end else begin
                state_d = bmprgb_pkg::ST_SKIP;
              end
            end
          end
          bmprgb_pkg::ST_SKIP: begin
            pos_d = pos_inc;
            if (pos_inc == offset_q) begin
              go_data = 1'b1;
            end
          end
          bmprgb_pkg::ST_DATA: begin
            unique case (idx_q)
              2'd0:    pix_d[7:0]   = data_byte_i;
              2'd1:    pix_d[15:8]  = data_byte_i;
              2'd2:    pix_d[23:16] = data_byte_i;
              default: pix_d        = pix_q;
            endcase
            if (idx_q != last_idx) begin
              idx_d = idx_q + 2'd1;
            end else begin
              push_o              = 1'b1;
              entry_o.cmd         = bmprgb_pkg::CMD_PIXEL;
              entry_o.dest_row    = height_q[7:0] - 8'(row_q) - 8'd1;
              entry_o.dest_column = 8'(col_q);
              entry_o.bgr         = is32 ? pix_q : {data_byte_i, pix_q[15:0]};
              entry_o.opaque      = is32 && data_byte_i[7];
              entry_o.width       = width_q[8:0];
              entry_o.height      = height_q[8:0];
              entry_o.has_mask    = is32;
              idx_d               = '0;
              pix_d               = '0;
              if (col_inc >= width_q[DW-1:0]) begin
                col_d = '0;
                row_d = row_inc;
                if (row_inc >= height_q[DW-1:0]) begin
                  entry_o.cmd = bmprgb_pkg::CMD_PIXEL_DONE;
                  state_d     = bmprgb_pkg::ST_IDLE;
                end else if (!is32 && width_q[1:0] != 2'd0) begin
                  pad_d   = width_q[1:0];
                  state_d = bmprgb_pkg::ST_PAD;
                end
              end else begin
                col_d = col_inc;
              end
            end
          end
          bmprgb_pkg::ST_PAD: begin
            pad_d = pad_q - 2'd1;
            if (pad_q <= 2'd1) begin
              state_d = bmprgb_pkg::ST_DATA;
            end
          end
          default: begin
            state_d = state_q;
          end
        endcase

        if (go_data) begin
          row_d = '0;
          col_d = '0;
          idx_d = '0;
          pix_d = '0;
          if (width_q == 32'd0 || height_q == 32'd0) begin
            push_o           = 1'b1;
            entry_o.cmd      = bmprgb_pkg::CMD_DONE;
            entry_o.width    = width_q[8:0];
            entry_o.height   = height_q[8:0];
            entry_o.has_mask = is32;
            state_d          = bmprgb_pkg::ST_IDLE;
          end else begin
            state_d = bmprgb_pkg::ST_DATA;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bmprgb_pkg::ST_FHDR;
      pos_q    <= '0;
      hdr_q    <= '0;
      width_q  <= '0;
      height_q <= '0;
      bpp_q    <= '0;
      offset_q <= '0;
      row_q    <= '0;
      col_q    <= '0;
      idx_q    <= '0;
      pix_q    <= '0;
      pad_q    <= '0;
      sig_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      hdr_q    <= hdr_d;
      width_q  <= width_d;
      height_q <= height_d;
      bpp_q    <= bpp_d;
      offset_q <= offset_d;
      row_q    <= row_d;
      col_q    <= col_d;
      idx_q    <= idx_d;
      pix_q    <= pix_d;
      pad_q    <= pad_d;
      sig_q    <= sig_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/bmprgb_queue.sv @@
// bmprgb_queue: short item queue between the front parser and the back formatter
// depends on bmprgb_pkg for the entry type and depth
`default_nettype none

module bmprgb_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire bmprgb_pkg::q_entry_t  entry_i,
  input  wire logic                  pop_i,
  output logic                       full_o,
  output logic                       empty_o,
  output bmprgb_pkg::q_entry_t       head_o
);

  localparam int unsigned PW = bmprgb_pkg::QPtrW;
  localparam int unsigned CW = bmprgb_pkg::QCntW;

  bmprgb_pkg::q_entry_t mem_q [bmprgb_pkg::QDepth];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(bmprgb_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/bmprgb_back.sv @@
// bmprgb_back: output register, rgb565 packing and pixel/done split
// depends on bmprgb_pkg; pulls entries from bmprgb_queue
`default_nettype none

module bmprgb_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  empty_i,
  input  wire bmprgb_pkg::q_entry_t  head_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [1:0]                 result_kind_o,
  output logic [7:0]                 dest_row_o,
  output logic [7:0]                 dest_column_o,
  output logic [15:0]                color565_o,
  output logic                       opaque_o,
  output logic [2:0]                 error_code_o,
  output logic [8:0]                 image_width_o,
  output logic [8:0]                 image_height_o,
  output logic                       has_mask_o
);

  bmprgb_pkg::q_entry_t ent_q;
  logic valid_q;
  logic second_q;
  logic take;
  logic free;
  logic split;
  logic show_pixel;
  logic show_done;

  assign take  = valid_q && !out_stall_i;
  assign free  = !valid_q || take;
  assign split = take && (ent_q.cmd == bmprgb_pkg::CMD_PIXEL_DONE) && !second_q;
  assign pop_o = free && !split && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else if (free) begin
      if (split) begin
        second_q <= 1'b1;
      end else begin
        valid_q  <= !empty_i;
        second_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q <= head_i;
    end
  end

  assign show_pixel = (ent_q.cmd == bmprgb_pkg::CMD_PIXEL) ||
                      (ent_q.cmd == bmprgb_pkg::CMD_PIXEL_DONE && !second_q);
  assign show_done  = (ent_q.cmd == bmprgb_pkg::CMD_DONE) ||
                      (ent_q.cmd == bmprgb_pkg::CMD_PIXEL_DONE && second_q);

  always_comb begin
    result_kind_o  = bmprgb_pkg::RES_ERROR;
    dest_row_o     = '0;
    dest_column_o  = '0;
    color565_o     = '0;
    opaque_o       = 1'b0;
    error_code_o   = '0;
    image_width_o  = '0;
    image_height_o = '0;
    has_mask_o     = 1'b0;
    priority if (show_pixel) begin
      result_kind_o = bmprgb_pkg::RES_PIXEL;
      dest_row_o    = ent_q.dest_row;
      dest_column_o = ent_q.dest_column;
      color565_o    = {ent_q.bgr[23:19], ent_q.bgr[15:10], ent_q.bgr[7:3]};
      opaque_o      = ent_q.opaque;
    end else if (show_done) begin
      result_kind_o  = bmprgb_pkg::RES_DONE;
      image_width_o  = ent_q.width;
      image_height_o = ent_q.height;
      has_mask_o     = ent_q.has_mask;
    end else begin
      error_code_o = ent_q.err;
    end
  end

  assign out_valid_o = valid_q;

endmodule

`default_nettype wire

@@ hdl/bmp_to_rgb565_stream_decoder.sv @@
// channel   dir  handshake             payload
// in        in   in_valid_i/in_stall_o kind_i, data_byte_i
// out       out  out_valid_o/out_stall_i result_kind_o .. has_mask_o
//
// one file byte accepted per cycle while the four-entry item queue has room
// a result passes through the item queue and then the output register after the byte that causes it;
// the last pixel gives two results, the pixel and then the done, from one queue entry
// in_stall_o is the queue full flag and does not depend on out_stall_i
// reset rearms the parser at the file header and empties queue and output
//
// top level of the bmp to rgb565 decoder: bmprgb_front, bmprgb_queue, bmprgb_back
// depends on bmprgb_pkg
`default_nettype none

module bmp_to_rgb565_stream_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        kind_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       result_kind_o,
  output logic [7:0]       dest_row_o,
  output logic [7:0]       dest_column_o,
  output logic [15:0]      color565_o,
  output logic             opaque_o,
  output logic [2:0]       error_code_o,
  output logic [8:0]       image_width_o,
  output logic [8:0]       image_height_o,
  output logic             has_mask_o
);

  logic                 accept;
  logic                 push;
  logic                 pop;
  logic                 full;
  logic                 empty;
  bmprgb_pkg::q_entry_t entry;
  bmprgb_pkg::q_entry_t head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  bmprgb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .push_o      (push),
    .entry_o     (entry)
  );

  bmprgb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  bmprgb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .dest_row_o     (dest_row_o),
    .dest_column_o  (dest_column_o),
    .color565_o     (color565_o),
    .opaque_o       (opaque_o),
    .error_code_o   (error_code_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o),
    .has_mask_o     (has_mask_o)
  );

endmodule

`default_nettype wire

@@ tb/bmp_to_rgb565_stream_decoder_test.sv @@
// testbench for bmp_to_rgb565_stream_decoder: feeds whole and broken bmp files byte by byte
// and checks every result against a behavioral decoder kept in this file or against a directed table
// depends on bmprgb_pkg and the decoder rtl
`timescale 1ns / 100ps

module bmp_to_rgb565_stream_decoder_test;
  import bmprgb_pkg::*;

  typedef enum logic [1:0] {
    CHK_MODEL = 2'd0,
    CHK_QUIET = 2'd1,
    CHK_ERROR = 2'd2
  } chk_e;

  typedef enum logic [1:0] {
    RX_OPEN     = 2'd0,
    RX_LIGHT    = 2'd1,
    RX_HEAVY    = 2'd2,
    RX_PERIODIC = 2'd3
  } rx_mode_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    chk_e       chk;
    err_e       code;
    logic       drain;
  } item_t;

  typedef struct packed {
    res_kind_e   kind;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [15:0] color;
    logic        opaque;
    err_e        code;
    logic [8:0]  w;
    logic [8:0]  h;
    logic        mask;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        kind_i = 1'b0;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  result_kind_o;
  logic [7:0]  dest_row_o;
  logic [7:0]  dest_column_o;
  logic [15:0] color565_o;
  logic        opaque_o;
  logic [2:0]  error_code_o;
  logic [8:0]  image_width_o;
  logic [8:0]  image_height_o;
  logic        has_mask_o;

  bmp_to_rgb565_stream_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .dest_row_o     (dest_row_o),
    .dest_column_o  (dest_column_o),
    .color565_o     (color565_o),
    .opaque_o       (opaque_o),
    .error_code_o   (error_code_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o),
    .has_mask_o     (has_mask_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // eof at reset, a short file header, a bad signature, bytes and eof after an error
  item_t directed_tab [24] = '{
    '{1'b1, 8'h00, CHK_ERROR, ERR_SHORT_FHDR, 1'b0},
    '{1'b1, 8'hFF, CHK_ERROR, ERR_SHORT_FHDR, 1'b0},
    '{1'b0, SigB,  CHK_QUIET, ERR_SHORT_FHDR, 1'b0},
    '{1'b0, SigM,  CHK_QUIET, ERR_SHORT_FHDR, 1'b0},
    '{1'b0, 8'hFF, CHK_QUIET, ERR_SHORT_FHDR, 1'b0},
    '{1'b0, 8'h00, CHK_QUIET, ERR_SHORT_FHDR, 1'b0},
    '{1'b1, 8'h00, CHK_ERROR, ERR_SHORT_FHDR, 1'b0},
    '{1'b0, SigM,  CHK_QUIET, ERR_SHORT_FHDR, 1'b0},
    '{1'b0, SigB,  CHK_QUIET, ERR_SHORT_FHDR, 1'b0},
    '{1'b0, 8'h00, CHK_QUIET, ERR_SHORT_FHDR, 1'b0},
    '{1'b0, 8'hFF, CHK_QUIET, ERR_SHORT_FHDR, 1'b0},
    '{1'b0, 8'h00, CHK_QUIET, ERR_SHORT_FHDR, 1'b0},
    '{1'b0, 8'hFF, CHK_QUIET, ERR_SHORT_FHDR, 1'b0},
    '{1'b0, 8'h00, CHK_QUIET, ERR_SHORT_FHDR, 1'b0},
    '{1'b0, 8'hFF, CHK_QUIET, ERR_SHORT_FHDR, 1'b0},
    '{1'b0, 8'h00, CHK_QUIET, ERR_SHORT_FHDR, 1'b0},
    '{1'b0, 8'hFF, CHK_QUIET, ERR_SHORT_FHDR, 1'b0},
    '{1'b0, 8'h36, CHK_QUIET, ERR_SHORT_FHDR, 1'b0},
    '{1'b0, 8'h00, CHK_QUIET, ERR_SHORT_FHDR, 1'b0},
    '{1'b0, 8'h00, CHK_QUIET, ERR_SHORT_FHDR, 1'b0},
    '{1'b0, 8'h00, CHK_ERROR, ERR_SIGNATURE,  1'b0},
    '{1'b0, 8'hA5, CHK_MODEL, ERR_SHORT_FHDR, 1'b0},
    '{1'b1, 8'h5A, CHK_QUIET, ERR_SHORT_FHDR, 1'b0},
    '{1'b1, 8'h00, CHK_ERROR, ERR_SHORT_FHDR, 1'b0}
  };

  item_t       file_items[$];
  result_t     decoded_results[$];
  result_t     step_results[$];
  logic [7:0]  file_bytes[$];
  bit          drain_next;
  int          files_built;
  int          items_in;
  int          wide_start;
  int          hold_at [3];
  int          mismatches;
  int          px_seen, done_seen, err_seen;
  bit [7:0]    codes_seen;

  // decoder state
  front_state_e dec_phase;
  bit [31:0]    byte_pos, hdr_size, img_w, img_h, data_off;
  bit [15:0]    bpp;
  bit [8:0]     src_row, src_col;
  bit [1:0]     pix_idx, pad_left;
  bit [23:0]    pix_bytes;
  bit           sig_good;

  task automatic decoder_reset();
    dec_phase = ST_FHDR;
    byte_pos  = '0;
    hdr_size  = '0;
    img_w     = '0;
    img_h     = '0;
    data_off  = '0;
    bpp       = '0;
    src_row   = '0;
    src_col   = '0;
    pix_idx   = '0;
    pad_left  = '0;
    pix_bytes = '0;
    sig_good  = 1'b0;
  endtask

  task automatic emit_error(err_e code);
    result_t r;
    r = '0;
    r.kind = RES_ERROR;
    r.code = code;
    step_results.push_back(r);
    dec_phase = ST_IDLE;
  endtask

  task automatic emit_done();
    result_t r;
    r = '0;
    r.kind = RES_DONE;
    r.w    = img_w[8:0];
    r.h    = img_h[8:0];
    r.mask = (bpp == Bpp32);
    step_results.push_back(r);
    dec_phase = ST_IDLE;
  endtask

  task automatic start_pixels();
    src_row   = '0;
    src_col   = '0;
    pix_idx   = '0;
    pix_bytes = '0;
    if (img_w == 0 || img_h == 0) emit_done();
    else dec_phase = ST_DATA;
  endtask

  task automatic decode_item(input bit kind, input bit [7:0] b);
    bit [31:0] idx;
    bit [1:0]  last_idx;
    result_t   r;
    if (kind) begin
      case (dec_phase)
        ST_FHDR:         emit_error(ERR_SHORT_FHDR);
        ST_INFO:         emit_error(ERR_SHORT_INFO);
        ST_SKIP:         emit_error(ERR_SEEK);
        ST_DATA, ST_PAD: emit_error(ERR_SHORT_DATA);
        default: ;
      endcase
      decoder_reset();
      return;
    end
    case (dec_phase)
      ST_FHDR: begin
        if (byte_pos == 0) sig_good = (b == SigB);
        else if (byte_pos == 1) sig_good = sig_good && (b == SigM);
        else if (byte_pos >= 10) data_off |= 32'(b) << (8 * (byte_pos - 10));
        byte_pos++;
        if (byte_pos == 14) begin
          if (!sig_good) emit_error(ERR_SIGNATURE);
          else dec_phase = ST_INFO;
        end
      end
      ST_INFO: begin
        idx = byte_pos - 14;
        if (idx < 4) hdr_size |= 32'(b) << (8 * idx);
        else if (idx < 8) img_w |= 32'(b) << (8 * (idx - 4));
        else if (idx < 12) img_h |= 32'(b) << (8 * (idx - 8));
        else if (idx == 14 || idx == 15) bpp |= 16'(b) << (8 * (idx - 14));
        byte_pos++;
        if (byte_pos == 54) begin
          if (hdr_size < InfoMinSize) emit_error(ERR_INFO_SIZE);
          else if (bpp != Bpp24 && bpp != Bpp32) emit_error(ERR_BPP);
          else if (img_w > MaxDim || img_h > MaxDim) emit_error(ERR_TOO_LARGE);
          else if (data_off < DataStart) emit_error(ERR_SEEK);
          else if (data_off == DataStart) start_pixels();
          else dec_phase = ST_SKIP;
        end
      end
      ST_SKIP: begin
        byte_pos++;
        if (byte_pos == data_off) start_pixels();
      end
      ST_DATA: begin
        last_idx = (bpp == Bpp32) ? 2'd3 : 2'd2;
        if (pix_idx < 3) pix_bytes |= 24'(b) << (8 * pix_idx);
        if (pix_idx < last_idx) begin
          pix_idx++;
        end else begin
          r = '0;
          r.kind   = RES_PIXEL;
          r.row    = img_h[7:0] - src_row[7:0] - 8'd1;
          r.col    = src_col[7:0];
          r.color  = {pix_bytes[23:19], pix_bytes[15:10], pix_bytes[7:3]};
          r.opaque = (bpp == Bpp32) && (b > 8'd127);
          step_results.push_back(r);
          pix_idx   = '0;
          pix_bytes = '0;
          src_col++;
          if (src_col >= img_w) begin
            src_col = '0;
            src_row++;
            if (src_row >= img_h) begin
              emit_done();
            end else if (bpp == Bpp24 && img_w[1:0] != 2'd0) begin
              pad_left  = 2'(32'd4 - ((img_w * 32'd3) & 32'd3));
              dec_phase = ST_PAD;
            end
          end
        end
      end
      ST_PAD: begin
        if (pad_left > 0) pad_left--;
        if (pad_left == 0) dec_phase = ST_DATA;
      end
      default: ;
    endcase
  endtask

  task automatic take_item(item_t it);
    result_t r;
    step_results.delete();
    decode_item(it.kind, it.data);
    case (it.chk)
      CHK_MODEL: foreach (step_results[i]) decoded_results.push_back(step_results[i]);
      CHK_ERROR: begin
        r = '0;
        r.kind = RES_ERROR;
        r.code = it.code;
        decoded_results.push_back(r);
      end
      default: ;
    endcase
    items_in++;
  endtask

  task automatic push_item(bit kind, bit [7:0] data);
    item_t s;
    s = '0;
    s.kind  = kind;
    s.data  = data;
    s.chk   = CHK_MODEL;
    s.drain = drain_next;
    drain_next = 1'b0;
    file_items.push_back(s);
  endtask

  task automatic put_le(bit [31:0] v, int nbytes);
    for (int i = 0; i < nbytes; i++) file_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic make_file(input bit [7:0] s0, input bit [7:0] s1, input bit [31:0] hsize,
                           input bit [31:0] w, input bit [31:0] h, input bit [15:0] bpp_v,
                           input bit [31:0] off, input int skip, input int rows);
    int px_bytes, pad;
    file_bytes.delete();
    file_bytes.push_back(s0);
    file_bytes.push_back(s1);
    repeat (8) file_bytes.push_back(8'($urandom));
    put_le(off, 4);
    put_le(hsize, 4);
    put_le(w, 4);
    put_le(h, 4);
    repeat (2) file_bytes.push_back(8'($urandom));
    put_le(32'(bpp_v), 2);
    repeat (24) file_bytes.push_back(8'($urandom));
    repeat (skip) file_bytes.push_back(8'($urandom));
    px_bytes = (bpp_v == Bpp32) ? 4 : 3;
    pad = (bpp_v == Bpp32) ? 0 : int'((32'd4 - (w * 32'd3) % 32'd4) % 32'd4);
    repeat (rows) begin
      repeat (int'(w) * px_bytes) file_bytes.push_back(8'($urandom));
      repeat (pad) file_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic add_random_file();
    int         pick, cut, skip, rows, n;
    bit [31:0]  hsize, w, h, off, v;
    bit [15:0]  bpp_v;
    bit [7:0]   s0, s1;
    bit         trail;
    pick = $urandom_range(0, 99);
    files_built++;
    drain_next = ($urandom_range(0, 11) == 0);
    s0 = SigB;
    s1 = SigM;
    hsize = $urandom_range(0, 1) ? InfoMinSize : $urandom;
    if (hsize < InfoMinSize) hsize = InfoMinSize;
    w = $urandom_range(1, 5);
    h = $urandom_range(1, 4);
    bpp_v = $urandom_range(0, 1) ? Bpp24 : Bpp32;
    skip = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
    off = DataStart + skip;
    rows = 0;
    cut = -1;
    if (pick < 45) begin
      if ($urandom_range(0, 9) == 0) w = 0;
      else if ($urandom_range(0, 9) == 0) h = 0;
      rows = h;
    end else if (pick < 50) begin
      // tallest image, cut short after a few rows
      w = 1;
      h = MaxDim;
      bpp_v = Bpp24;
      rows = 4;
    end else if (pick < 57) begin
      if ($urandom_range(0, 1)) s0 = s0 ^ 8'($urandom_range(1, 255));
      else s1 = s1 ^ 8'($urandom_range(1, 255));
    end else if (pick < 62) begin
      cut = $urandom_range(0, 13);
    end else if (pick < 68) begin
      cut = $urandom_range(14, 53);
    end else if (pick < 74) begin
      hsize = $urandom_range(0, 39);
    end else if (pick < 81) begin
      bpp_v = 16'($urandom);
      if ($urandom_range(0, 1)) bpp_v = bpp_v & 16'h003F;
      if (bpp_v == Bpp24 || bpp_v == Bpp32) bpp_v = bpp_v + 16'd1;
    end else if (pick < 87) begin
      v = $urandom_range(0, 1) ? $urandom_range(MaxDim + 1, 2 * MaxDim) : $urandom;
      if (v <= MaxDim) v = MaxDim + 1;
      case ($urandom_range(0, 2))
        0: w = v;
        1: h = v;
        default: begin
          w = v;
          h = v;
        end
      endcase
    end else if (pick < 92) begin
      off = $urandom_range(0, 53);
      skip = 0;
    end else if (pick < 96) begin
      // far data offset, file ends while skipping
      off = $urandom_range(0, 1) ? $urandom_range(64, 4096) : ($urandom | 32'h0000_1000);
      skip = 8;
      cut = $urandom_range(54, 61);
    end else begin
      n = $urandom_range(10, 60);
      repeat (n) push_item($urandom_range(0, 15) == 0, 8'($urandom));
      push_item(1'b1, 8'($urandom));
      return;
    end
    make_file(s0, s1, hsize, w, h, bpp_v, off, skip, rows);
    if (pick < 45 && file_bytes.size() > off && $urandom_range(0, 3) == 0)
      cut = $urandom_range(off, file_bytes.size() - 1);
    if (pick >= 45 && pick < 50) cut = file_bytes.size();
    if (cut < 0) begin
      n = file_bytes.size();
      trail = 1'b1;
    end else begin
      n = cut;
      trail = 1'b0;
    end
    for (int i = 0; i < n; i++) push_item(1'b0, file_bytes[i]);
    if (trail) repeat ($urandom_range(0, 3)) push_item(1'b0, 8'($urandom));
    push_item(1'b1, 8'($urandom));
  endtask

  task automatic build_stimulus();
    int  small_items, start_size;
    bit  wide_done;
    foreach (directed_tab[i]) file_items.push_back(directed_tab[i]);
    small_items = 0;
    wide_done = 1'b0;
    while (small_items < 850) begin
      if (!wide_done && small_items >= 700) begin
        // widest image in full, sent only after the decoder has drained
        wide_start = file_items.size();
        files_built++;
        drain_next = 1'b1;
        make_file(SigB, SigM, InfoMinSize, MaxDim, 1, Bpp24, DataStart, 0, 1);
        foreach (file_bytes[i]) push_item(1'b0, file_bytes[i]);
        push_item(1'b1, 8'h00);
        wide_done = 1'b1;
      end
      start_size = file_items.size();
      add_random_file();
      small_items += file_items.size() - start_size;
    end
    hold_at[0] = 300;
    hold_at[1] = wide_start + 100;
    hold_at[2] = wide_start + 600;
  endtask

  initial begin : sender
    int burst_left, gap_left, end_wait;
    decoder_reset();
    build_stimulus();
    burst_left = 0;
    gap_left = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (file_items.size() != 0) begin
      @(posedge clk_i);
      if (in_valid_i && !in_stall_o) begin
        take_item(file_items.pop_front());
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (file_items.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (file_items[0].drain && decoded_results.size() != 0) begin
          in_valid_i <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i  <= 1'b1;
          kind_i      <= file_items[0].kind;
          data_byte_i <= file_items[0].data;
        end
      end
    end
    end_wait = 0;
    while (decoded_results.size() != 0 && end_wait < 20000) begin
      @(posedge clk_i);
      end_wait++;
    end
    repeat (20) @(posedge clk_i);
    if (decoded_results.size() != 0) begin
      $error("%0d expected results never arrived", decoded_results.size());
      mismatches++;
    end
    $display("run covered %0d items in %0d files: %0d pixels, %0d images done, %0d errors",
             items_in, files_built, px_seen, done_seen, err_seen);
    $display("error codes reported (bit per code): %b", codes_seen);
    if (mismatches == 0) begin
      $display("PASS bmp_to_rgb565_stream_decoder");
    end else begin
      $display("FAIL bmp_to_rgb565_stream_decoder");
    end
    $finish;
  end

  // receiver: changing stall patterns plus a few long hold-offs
  int       rx_cycle;
  int       hold_left;
  int       holds_done;
  rx_mode_e rx_mode = RX_OPEN;

  always @(posedge clk_i) begin
    rx_cycle++;
    if (hold_left == 0 && holds_done < 3 && items_in >= hold_at[holds_done] && items_in > 0) begin
      hold_left = 150;
      holds_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (rx_cycle % 200 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
      case (rx_mode)
        RX_OPEN:  out_stall_i <= 1'b0;
        RX_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:  out_stall_i <= ((rx_cycle % 5) < 2);
      endcase
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 40) $error("%s: expected %0h, actual %0h", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      case (result_kind_o)
        RES_PIXEL: px_seen++;
        RES_DONE:  done_seen++;
        default: begin
          err_seen++;
          codes_seen[error_code_o] = 1'b1;
        end
      endcase
      if (decoded_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 40) $error("result with no expectation, kind %0d", result_kind_o);
      end else begin
        want = decoded_results.pop_front();
        check_field("result_kind", want.kind, result_kind_o);
        check_field("dest_row", want.row, dest_row_o);
        check_field("dest_column", want.col, dest_column_o);
        check_field("color565", want.color, color565_o);
        check_field("opaque", want.opaque, opaque_o);
        check_field("error_code", want.code, error_code_o);
        check_field("image_width", want.w, image_width_o);
        check_field("image_height", want.h, image_height_o);
        check_field("has_mask", want.mask, has_mask_o);
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("FAIL bmp_to_rgb565_stream_decoder");
    $finish;
  end

endmodule
